/* src/tdl_pkg.sv */
package tdl_pkg;
  localparam int NODE_W = 10;
  localparam int MAX_NODES = 1024;
  localparam int LIFT_LEVELS = 10;
  localparam int LVL_W = 4;
  localparam int DEPTH_W = 11;
  localparam int DIST_W = 32;
  localparam int WEIGHT_W = 16;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;
  localparam logic [NODE_W-1:0] ROOT_RESET = NODE_W'(1);
  localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(LIFT_LEVELS - 1);
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_QUERY = 1'b1;
  localparam logic [1:0] REG_ROOT = 2'd0;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LD_RD,
    S_LD_WR0,
    S_LD_RDA,
    S_LD_RDB,
    S_LD_WRI,
    S_Q_RD,
    S_Q_SW,
    S_Q_UPRD,
    S_Q_UPCK,
    S_Q_EQ,
    S_Q_BRD,
    S_Q_BCK,
    S_Q_FIN,
    S_Q_DST,
    S_Q_WT,
    S_OUT
  } state_t;

  // controller -> datapath commands
  typedef struct packed {
    logic       capture;   // latch input item
    logic       rd_ab;     // read depth/dist of a and b
    logic       ld_wr0;    // write depth, dist, level 0
    logic       rd_anc_a;  // read anc[a][lvl] (and anc[b][lvl])
    logic       rd_anc_x;  // read anc[x][lvl], x = fetched entry
    logic       ld_wri;    // write anc[v][lvl]
    logic       q_swap;    // order a/b by depth
    logic       up_chk;    // conditional lift of a
    logic       br_chk;    // conditional lift of both
    logic       fin;       // a = anc[a][0]
    logic       rd_dist_l; // read dist of lca
    logic       out_load;  // load output register
    logic [LVL_W-1:0] lvl;
  } cmd_t;

  typedef struct packed {
    logic skip_load; // loaded node is root
    logic a_eq_b;
  } sts_t;
endpackage

/* src/tdl_ctrl.sv */
module tdl_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            req_type,
  input  logic            out_busy,
  input  tdl_pkg::sts_t   sts,
  output tdl_pkg::cmd_t   cmd
);
  import tdl_pkg::*;
  state_t state, state_next;
  logic [LVL_W-1:0] lvl, lvl_next;
  logic is_q, is_q_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      lvl <= '0;
      is_q <= 1'b0;
    end else begin
      state <= state_next;
      lvl <= lvl_next;
      is_q <= is_q_next;
    end
  end

  always_comb begin
    state_next = state;
    lvl_next = lvl;
    is_q_next = is_q;
    cmd = '0;
    cmd.lvl = lvl;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          is_q_next = (req_type == REQ_QUERY);
          state_next = S_LD_RD;
        end
      end
      S_LD_RD: begin
        cmd.rd_ab = 1'b1;
        state_next = is_q ? S_Q_SW : S_LD_WR0;
      end
      S_LD_WR0: begin
        if (sts.skip_load) state_next = S_IDLE;
        else begin
          cmd.ld_wr0 = 1'b1;
          lvl_next = LVL_W'(1);
          state_next = (LIFT_LEVELS > 1) ? S_LD_RDA : S_IDLE;
        end
      end
      S_LD_RDA: begin
        cmd.lvl = lvl - LVL_W'(1);
        cmd.rd_anc_a = 1'b1;
        state_next = S_LD_RDB;
      end
      S_LD_RDB: begin
        cmd.lvl = lvl - LVL_W'(1);
        cmd.rd_anc_x = 1'b1;
        state_next = S_LD_WRI;
      end
      S_LD_WRI: begin
        cmd.ld_wri = 1'b1;
        if (lvl == LAST_LVL) state_next = S_IDLE;
        else begin
          lvl_next = lvl + LVL_W'(1);
          state_next = S_LD_RDA;
        end
      end
      S_Q_SW: begin
        cmd.q_swap = 1'b1;
        lvl_next = LAST_LVL;
        state_next = S_Q_UPRD;
      end
      S_Q_UPRD: begin
        cmd.rd_anc_a = 1'b1;
        state_next = S_Q_RD;
      end
      S_Q_RD: begin
        cmd.rd_anc_x = 1'b1; // depth of the candidate
        state_next = S_Q_UPCK;
      end
      S_Q_UPCK: begin
        cmd.up_chk = 1'b1;
        if (lvl == '0) state_next = S_Q_EQ;
        else begin
          lvl_next = lvl - LVL_W'(1);
          state_next = S_Q_UPRD;
        end
      end
      S_Q_EQ: begin
        lvl_next = LAST_LVL;
        state_next = sts.a_eq_b ? S_Q_DST : S_Q_BRD;
      end
      S_Q_BRD: begin
        cmd.rd_anc_a = 1'b1;
        state_next = S_Q_BCK;
      end
      S_Q_BCK: begin
        cmd.br_chk = 1'b1;
        if (lvl == '0) state_next = S_Q_FIN;
        else begin
          lvl_next = lvl - LVL_W'(1);
          state_next = S_Q_BRD;
        end
      end
      S_Q_FIN: begin
        cmd.lvl = '0;
        cmd.rd_anc_a = 1'b1;
        cmd.fin = 1'b1;
        state_next = S_Q_DST;
      end
      S_Q_DST: begin
        cmd.rd_dist_l = 1'b1;
        state_next = S_Q_WT;
      end
      S_Q_WT: begin
        // lca distance lands in the datapath this cycle
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_busy) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

/* src/tdl_dp.sv */
module tdl_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  tdl_pkg::cmd_t                 cmd,
  output tdl_pkg::sts_t                 sts,
  input  logic [tdl_pkg::NODE_W-1:0]    root,
  input  logic [tdl_pkg::NODE_W-1:0]    node_a,
  input  logic [tdl_pkg::NODE_W-1:0]    node_b,
  input  logic [tdl_pkg::WEIGHT_W-1:0]  edge_weight,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          out_busy,
  output logic [tdl_pkg::DIST_W-1:0]    path_distance,
  output logic [tdl_pkg::NODE_W-1:0]    common_ancestor
);
  import tdl_pkg::*;
  localparam int ANC_AW = NODE_W + LVL_W;

  logic [DEPTH_W-1:0] depth_mem [MAX_NODES];
  logic [DIST_W-1:0]  dist_mem [MAX_NODES];
  logic [NODE_W-1:0]  anc_mem [MAX_NODES*16];

  logic [NODE_W-1:0] a, b, x;
  logic [WEIGHT_W-1:0] w;
  logic [DEPTH_W-1:0] db;
  logic [DIST_W-1:0] sa, sb;
  // registered raw reads
  logic [NODE_W-1:0] anc_q1, anc_q2;
  logic [DEPTH_W-1:0] dep_q1, dep_q2;
  logic [DIST_W-1:0] dst_q1, dst_q2;
  logic [NODE_W-1:0] rn1, rn2;

  // pipeline tracking: which command issued last cycle
  logic p_rd_ab, p_anc_a, p_fin, p_dst;
  always_ff @(posedge clk) begin
    if (rst) begin
      p_rd_ab <= 1'b0; p_anc_a <= 1'b0;
      p_fin <= 1'b0; p_dst <= 1'b0;
    end else begin
      p_rd_ab <= cmd.rd_ab; p_anc_a <= cmd.rd_anc_a;
      p_fin <= cmd.fin; p_dst <= cmd.rd_dist_l;
    end
  end

  // root overrides on registered reads
  logic [NODE_W-1:0] anc1, anc2;
  logic [DEPTH_W-1:0] dep1, dep2;
  logic [DIST_W-1:0] dst1, dst2;
  always_comb begin
    anc1 = (rn1 == root) ? root : anc_q1;
    anc2 = (rn2 == root) ? root : anc_q2;
    dep1 = (rn1 == root) ? DEPTH_W'(1) : dep_q1;
    dep2 = (rn2 == root) ? DEPTH_W'(1) : dep_q2;
    dst1 = (rn1 == root) ? '0 : dst_q1;
    dst2 = (rn2 == root) ? '0 : dst_q2;
  end

  // address muxes: port1 and port2; port1 chases a just-fetched entry
  logic [NODE_W-1:0] ad1, ad2;
  always_comb begin
    ad1 = a;
    ad2 = b;
    if (cmd.rd_anc_x || (cmd.rd_dist_l && p_fin)) ad1 = anc1;
  end

  always_ff @(posedge clk) begin
    anc_q1 <= anc_mem[{ad1, cmd.lvl}];
    anc_q2 <= anc_mem[{ad2, cmd.lvl}];
    dep_q1 <= depth_mem[ad1];
    dep_q2 <= depth_mem[ad2];
    dst_q1 <= dist_mem[ad1];
    dst_q2 <= dist_mem[ad2];
    rn1 <= ad1;
    rn2 <= ad2;
    if (cmd.ld_wr0) begin
      depth_mem[a] <= (dep2 == DEPTH_MAX) ? DEPTH_MAX : dep2 + DEPTH_W'(1);
      dist_mem[a] <= ({1'b0, dst2} + {{(DIST_W-WEIGHT_W+1){1'b0}}, w}) > {1'b0, DIST_MAX}
                     ? DIST_MAX : dst2 + DIST_W'(w);
      anc_mem[{a, LVL_W'(0)}] <= b;
    end
    if (cmd.ld_wri) anc_mem[ANC_AW'({a, cmd.lvl})] <= anc1;
  end

  logic [DIST_W:0] sum;
  logic [DIST_W+1:0] diff;
  logic [DIST_W-1:0] res_dist;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      a <= node_a; b <= node_b; w <= edge_weight;
    end
    if (cmd.q_swap && dep1 < dep2) begin
      a <= b; b <= a; db <= dep1; sa <= dst2; sb <= dst1;
    end else if (p_rd_ab) begin
      db <= dep2; sa <= dst1; sb <= dst2;
    end
    if (p_anc_a) x <= anc1;
    if (cmd.up_chk && dep1 >= db) a <= x;
    if (cmd.br_chk && anc1 != anc2) begin
      a <= anc1; b <= anc2;
    end
    if (p_fin) a <= anc1;
    if (p_dst) res_dist <= dst1;
  end

  // lca is in a once its distance is captured (port1 reads a, or the entry fetched by fin)
  always_comb begin
    sum = {1'b0, sa} + {1'b0, sb};
    diff = {1'b0, sum} - {1'b0, res_dist, 1'b0};
  end

  logic [NODE_W-1:0] lca_q;
  always_ff @(posedge clk) if (p_dst) lca_q <= a;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
    if (cmd.out_load) begin
      common_ancestor <= lca_q;
      if (diff[DIST_W+1]) path_distance <= '0;
      else if (diff[DIST_W]) path_distance <= DIST_MAX;
      else path_distance <= diff[DIST_W-1:0];
    end
  end

  assign out_busy = out_valid && !out_ready;
  assign sts.skip_load = (a == root);
  assign sts.a_eq_b = (a == b);
endmodule

/* src/tree_distance_lca_engine.sv */
// channel | signals                                   | accepted when
// in      | in_valid/in_ready, req_type..edge_weight  | in_valid && in_ready
// out     | out_valid/out_ready, path_distance, lca   | out_valid && out_ready
// cfg     | APB psel/penable/pwrite/paddr/pwdata      | psel&&penable&&pwrite
// A load writes nothing if it targets the root; a query makes its lifting steps
// through table reads on the registered memory ports.
// rst is synchronous and clears the controller, root register and output valid.
// Input is taken only in idle; the output register holds a result while stalled.
module tree_distance_lca_engine (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic         req_type,
  input  logic [9:0]   node_a,
  input  logic [9:0]   node_b,
  input  logic [15:0]  edge_weight,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [31:0]  path_distance,
  output logic [9:0]   common_ancestor,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [1:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import tdl_pkg::*;
  logic [NODE_W-1:0] root;
  cmd_t cmd;
  sts_t sts;
  logic out_busy;

  always_ff @(posedge clk) begin
    if (rst) root <= ROOT_RESET;
    else if (psel && penable && pwrite && paddr == REG_ROOT) root <= pwdata[NODE_W-1:0];
  end
  assign pready = 1'b1;
  assign prdata = (paddr == REG_ROOT) ? {{(32-NODE_W){1'b0}}, root} : '0;

  tdl_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .out_busy(out_busy), .sts(sts), .cmd(cmd)
  );

  tdl_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .root(root),
    .node_a(node_a), .node_b(node_b), .edge_weight(edge_weight),
    .out_ready(out_ready), .out_valid(out_valid), .out_busy(out_busy),
    .path_distance(path_distance), .common_ancestor(common_ancestor)
  );
endmodule
